// ----- src/cmi_pkg.sv -----
// shared constants, codes and helpers for the colormap interpolator
package cmi_pkg;

  // fixed field widths of the channels
  localparam int OPCODE_W      = 1;
  localparam int ENTRY_INDEX_W = 6;
  localparam int COLOR_W       = 32;
  localparam int SAMPLE_W      = 32;
  localparam int COUNT_W       = 7;
  localparam int LANES         = 4;
  localparam int LANE_W        = 8;

  // entry count widths: saturated count fits 9 bits, count minus one fits 8
  localparam int COUNT_EXT_W = 9;
  localparam int NM1_W       = 8;

  // defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF   = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // entries in use after reset
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_MAP  = 1'b1;

  // job modes carried through the queue
  localparam int MODE_W = 2;
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_ZERO  = 2'd1;
  localparam mode_t MODE_BLEND = 2'd2;

  // width of one packed job word
  function automatic int job_width(int idx_w, int frac_w);
    return MODE_W + 2 * idx_w + frac_w + COLOR_W;
  endfunction

endpackage

// ----- src/cmi_if.sv -----
// channel interfaces: input transactions and result transactions

interface cmi_in_if;
  import cmi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ENTRY_INDEX_W-1:0]   entry_index;
  logic [COLOR_W-1:0]         entry_color;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       not_finite;

  modport source (
    output valid, opcode, entry_index, entry_color, sample, not_finite,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_color, sample, not_finite,
    output ready
  );
endinterface

interface cmi_out_if;
  import cmi_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

// ----- src/cmi_queue.sv -----
// small register queue that decouples the front from the back
module cmi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cmi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import cmi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/cmi_front.sv -----
// front: accepts transactions, holds the entry count, classifies and scales samples
module cmi_front #(
  parameter int TABLE_DEPTH   = cmi_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = cmi_pkg::FRACTION_BITS_DEF,
  parameter int JOB_W         = cmi_pkg::job_width($clog2(TABLE_DEPTH), FRACTION_BITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cmi_pkg::COUNT_W-1:0] cfg_wdata,
  cmi_in_if.sink                      in_ch,
  output logic                        q_push,
  output logic [JOB_W-1:0]            q_data,
  input  logic                        q_full
);
  import cmi_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PROD_W = FRACTION_BITS + NM1_W;
  localparam logic [COUNT_EXT_W-1:0] DEPTH_EXT = COUNT_EXT_W'(TABLE_DEPTH);
  localparam logic [COUNT_EXT_W-1:0] MIN_EXT   = COUNT_EXT_W'(2);

  typedef struct packed {
    mode_t                    mode;
    logic [IDX_W-1:0]         addr_a;
    logic [IDX_W-1:0]         addr_b;
    logic [FRACTION_BITS-1:0] frac;
    logic [COLOR_W-1:0]       color;
  } job_t;

  logic [COUNT_W-1:0]     count_r;
  logic                   s1_v_r;
  mode_t                  s1_mode_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic [COLOR_W-1:0]     s1_color_r;
  logic [PROD_W-1:0]      s1_prod_r;

  logic [COUNT_EXT_W-1:0] n_ext, n_sat, n_m1_ext;
  logic [NM1_W-1:0]       n_m1;
  logic [COUNT_EXT_W-1:0] load_idx_ext;
  logic                   accept, keep;
  logic                   le_zero, ge_one;
  logic [PROD_W-1:0]      prod_mul, prod_sel;
  mode_t                  mode_sel;
  logic [IDX_W-1:0]       map_idx;
  job_t                   job;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // saturate the entry count to the table
  always_comb begin
    n_ext = COUNT_EXT_W'(count_r);
    if (n_ext < MIN_EXT) begin
      n_sat = MIN_EXT;
    end else if (n_ext > DEPTH_EXT) begin
      n_sat = DEPTH_EXT;
    end else begin
      n_sat = n_ext;
    end
    n_m1_ext = n_sat - 1'b1;
    n_m1     = n_m1_ext[NM1_W-1:0];
  end

  assign in_ch.ready = !s1_v_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the incoming transaction
  always_comb begin
    load_idx_ext = COUNT_EXT_W'(in_ch.entry_index);
    le_zero  = in_ch.sample[SAMPLE_W-1] || (in_ch.sample == '0);
    ge_one   = !in_ch.sample[SAMPLE_W-1] &&
               (in_ch.sample[SAMPLE_W-1:FRACTION_BITS] != '0);
    prod_mul = PROD_W'(in_ch.sample[FRACTION_BITS-1:0]) * PROD_W'(n_m1);
    if (le_zero) begin
      prod_sel = '0;
    end else if (ge_one) begin
      prod_sel = {n_m1, {FRACTION_BITS{1'b0}}};
    end else begin
      prod_sel = prod_mul;
    end
    if (in_ch.opcode == OP_LOAD) begin
      mode_sel = MODE_LOAD;
      keep     = (load_idx_ext < DEPTH_EXT);
    end else if (in_ch.not_finite) begin
      mode_sel = MODE_ZERO;
      keep     = 1'b1;
    end else begin
      mode_sel = MODE_BLEND;
      keep     = 1'b1;
    end
  end

  // stage register after the multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r  <= mode_sel;
      s1_idx_r   <= load_idx_ext[IDX_W-1:0];
      s1_color_r <= in_ch.entry_color;
      s1_prod_r  <= prod_sel;
    end
  end

  // split the scaled sample into index and fraction
  // a zero fraction reads the same entry twice, so the top entry never reads past it
  always_comb begin
    map_idx    = s1_prod_r[FRACTION_BITS +: IDX_W];
    job.mode   = s1_mode_r;
    job.color  = s1_color_r;
    if (s1_mode_r == MODE_LOAD) begin
      job.addr_a = s1_idx_r;
      job.addr_b = s1_idx_r;
      job.frac   = '0;
    end else begin
      job.addr_a = map_idx;
      job.addr_b = (s1_prod_r[FRACTION_BITS-1:0] == '0) ? map_idx : map_idx + 1'b1;
      job.frac   = s1_prod_r[FRACTION_BITS-1:0];
    end
  end

  assign q_push = s1_v_r && !q_full;
  assign q_data = job;

endmodule

// ----- src/cmi_back.sv -----
// back: owns the colour table, reads two neighbors and blends the four channels
module cmi_back #(
  parameter int TABLE_DEPTH   = cmi_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = cmi_pkg::FRACTION_BITS_DEF,
  parameter int JOB_W         = cmi_pkg::job_width($clog2(TABLE_DEPTH), FRACTION_BITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [JOB_W-1:0] q_data,
  output logic             q_pop,
  cmi_out_if.source        out_ch
);
  import cmi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int MUL_W = LANE_W + 1 + FRACTION_BITS + 1;

  typedef struct packed {
    mode_t                    mode;
    logic [IDX_W-1:0]         addr_a;
    logic [IDX_W-1:0]         addr_b;
    logic [FRACTION_BITS-1:0] frac;
    logic [COLOR_W-1:0]       color;
  } job_t;

  logic [COLOR_W-1:0]       table_mem [TABLE_DEPTH];
  logic [COLOR_W-1:0]       rd_a_r, rd_b_r;
  logic [FRACTION_BITS-1:0] b1_frac_r;
  logic                     b1_zero_r;
  logic                     b1_v_r;
  logic                     out_v_r;
  logic [COLOR_W-1:0]       out_data_r;

  job_t                     head;
  logic                     head_is_load;
  logic                     out_take, b1_ready, rd_en;
  logic [COLOR_W-1:0]       blend_w;

  assign head         = q_data;
  assign head_is_load = (head.mode == MODE_LOAD);
  assign out_take     = !out_v_r || out_ch.ready;
  assign b1_ready     = !b1_v_r || out_take;
  assign q_pop        = q_valid && (head_is_load || b1_ready);
  assign rd_en        = q_pop && !head_is_load;

  // table write for load transactions
  always_ff @(posedge clk) begin
    if (q_pop && head_is_load) begin
      table_mem[head.addr_a] <= head.color;
    end
  end

  // registered read of the two neighboring entries
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r    <= table_mem[head.addr_a];
      rd_b_r    <= table_mem[head.addr_b];
      b1_frac_r <= head.frac;
      b1_zero_r <= (head.mode == MODE_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (b1_ready) begin
      b1_v_r <= rd_en;
    end
  end

  // per-channel blend a + ((b - a) * frac) >> fraction bits
  always_comb begin
    logic signed [MUL_W-1:0] diff;
    logic signed [MUL_W-1:0] frac_s;
    logic signed [MUL_W-1:0] mul;
    logic signed [MUL_W-1:0] shifted;
    logic [LANE_W-1:0]       ca, cb;
    blend_w = '0;
    for (int l = 0; l < LANES; l++) begin
      ca      = rd_a_r[l*LANE_W +: LANE_W];
      cb      = rd_b_r[l*LANE_W +: LANE_W];
      diff    = $signed(MUL_W'(cb)) - $signed(MUL_W'(ca));
      frac_s  = $signed(MUL_W'(b1_frac_r));
      mul     = diff * frac_s;
      shifted = mul >>> FRACTION_BITS;
      blend_w[l*LANE_W +: LANE_W] = ca + shifted[LANE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && b1_v_r) begin
      out_data_r <= b1_zero_r ? '0 : blend_w;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_color = out_data_r;

  // read data must hold while the blend stage waits on the output
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_v_r && !out_take) |=> (b1_v_r && $stable(rd_a_r) && $stable(rd_b_r)))
    else $error("blend stage lost its read data under stall");

  // a popped map transaction always lands in the blend stage
  a_map_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !head_is_load) |=> b1_v_r)
    else $error("map transaction dropped after pop");

  // a result only appears after the blend stage held one
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(b1_v_r))
    else $error("result raised without a blend stage transaction");

endmodule

// ----- src/colormap_interpolator.sv -----
// colormap interpolator top level: front, queue and back
//
// Usage:
//   in_ch carries load and map transactions. A load (opcode 0) writes
//   entry_color into table entry entry_index and gives no result; a load
//   beyond the table is dropped. A map (opcode 1) turns a Q15.16 sample into
//   a 32-bit colour on out_ch: 0 when not_finite is set, the first entry at
//   or below zero, the last entry in use at or above one, else a linear blend
//   of two neighboring entries, per 8-bit channel, truncated.
//   cfg_we/cfg_wdata set the number of entries in use (2..table depth after
//   saturation); write it only while no transaction is in flight.
// Timing:
//   one transaction per cycle sustained while out_ch.ready is high; a map
//   result passes the sample scaling register, queue, table read register
//   and output register. Loads and maps keep their order through the queue.
// Reset:
//   entries in use returns to 64, queue and pipeline empty; the table keeps
//   whatever it held and must be loaded before use.
// Stall:
//   when out_ch.ready is low the output and blend stages hold, the queue
//   fills, and in_ch.ready drops once the queue and scaling stage are full.
module colormap_interpolator #(
  parameter int TABLE_DEPTH   = cmi_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = cmi_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cmi_pkg::COUNT_W-1:0] cfg_wdata,
  cmi_in_if.sink                      in_ch,
  cmi_out_if.source                   out_ch
);
  import cmi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int JOB_W = job_width(IDX_W, FRACTION_BITS);

  logic             q_push, q_full, q_pop, q_valid;
  logic [JOB_W-1:0] q_in_data, q_out_data;

  // classify and scale
  cmi_front #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS),
    .JOB_W         (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_push    (q_push),
    .q_data    (q_in_data),
    .q_full    (q_full)
  );

  // decoupling queue
  cmi_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out_data)
  );

  // table and blend
  cmi_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS),
    .JOB_W         (JOB_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_out_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/colormap_interpolator_tb.sv -----
// testbench for colormap_interpolator: directed and random transactions checked against a predictor
`timescale 1ns / 100ps

module colormap_interpolator_tb;
  import cmi_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int ONE = 1 << FB;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS = 1_000_000;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [ENTRY_INDEX_W-1:0]   entry_index;
    logic [COLOR_W-1:0]         entry_color;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       not_finite;
  } cmap_txn_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  cmi_in_if  in_ch();
  cmi_out_if out_ch();

  colormap_interpolator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state: copy of the colour table and the entry count
  logic [COLOR_W-1:0] palette [DEPTH];
  logic [COUNT_W-1:0] entries_setting;
  logic [COLOR_W-1:0] expected_pixels [$];

  int errors;
  bit send_gaps;
  bit rx_stalls;
  int rx_hold_req;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // safety net
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // count of entries after saturation
  function automatic int used_entries();
    if (entries_setting < 2) return 2;
    if (entries_setting > DEPTH) return DEPTH;
    return int'(entries_setting);
  endfunction

  // per channel blend a + (b - a) * frac, truncated
  function automatic logic [COLOR_W-1:0] blend_colors(logic [COLOR_W-1:0] lo,
                                                      logic [COLOR_W-1:0] hi,
                                                      logic [FB-1:0] frac);
    logic [COLOR_W-1:0] res;
    longint a;
    longint b;
    longint v;
    res = '0;
    for (int ch = 0; ch < LANES; ch++) begin
      a = longint'(lo[LANE_W*ch +: LANE_W]);
      b = longint'(hi[LANE_W*ch +: LANE_W]);
      v = a * ONE + (b - a) * longint'(frac);
      res[LANE_W*ch +: LANE_W] = v[FB +: LANE_W];
    end
    return res;
  endfunction

  // expected colour for one map transaction
  function automatic logic [COLOR_W-1:0] mapped_color(logic signed [SAMPLE_W-1:0] s,
                                                      logic nf);
    int n;
    longint scaled;
    int idx;
    logic [FB-1:0] frac;
    n = used_entries();
    if (nf) return '0;
    if (s <= 0) return palette[0];
    if (s >= ONE) return palette[n-1];
    scaled = longint'(s) * longint'(n - 1);
    idx = int'(scaled >>> FB);
    frac = scaled[FB-1:0];
    if (idx > n - 2) idx = n - 2;
    return blend_colors(palette[idx], palette[idx+1], frac);
  endfunction

  function automatic cmap_txn_t make_map(logic signed [SAMPLE_W-1:0] s, logic nf);
    cmap_txn_t t;
    t.opcode = OP_MAP;
    t.entry_index = ENTRY_INDEX_W'($urandom_range(0, DEPTH - 1));
    t.entry_color = $urandom();
    t.sample = s;
    t.not_finite = nf;
    return t;
  endfunction

  function automatic cmap_txn_t make_load(int idx, logic [COLOR_W-1:0] color);
    cmap_txn_t t;
    t.opcode = OP_LOAD;
    t.entry_index = ENTRY_INDEX_W'(idx);
    t.entry_color = color;
    t.sample = $urandom();
    t.not_finite = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // sample mix: mostly inside (0,1), some boundaries, rest anywhere
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, ONE - 1);
    if (r == 6) begin
      case ($urandom_range(0, 6))
        0: return 0;
        1: return 1;
        2: return ONE - 1;
        3: return ONE;
        4: return 32'sh8000_0000;
        5: return 32'sh7fff_ffff;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  // drive one transaction and wait for its handshake
  task automatic send_txn(cmap_txn_t t);
    int gap;
    gap = 0;
    if (send_gaps && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= t.opcode;
    in_ch.entry_index <= t.entry_index;
    in_ch.entry_color <= t.entry_color;
    in_ch.sample <= t.sample;
    in_ch.not_finite <= t.not_finite;
    do @(posedge clk); while (!in_ch.ready);
    if (t.opcode == OP_MAP) begin
      expected_pixels.push_back(mapped_color(t.sample, t.not_finite));
    end else begin
      palette[t.entry_index] = t.entry_color;
    end
  endtask

  // stop offering, wait for all results, then let loads settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [COUNT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    entries_setting = v;
  endtask

  // every entry loaded once, with hard colours at the low end and in the top entry
  task automatic test_table_fill();
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: send_txn(make_load(i, 32'h0000_0000));
        1: send_txn(make_load(i, 32'hffff_ffff));
        2: send_txn(make_load(i, 32'hff00_ff00));
        DEPTH - 1: send_txn(make_load(i, 32'hffff_ffff));
        default: send_txn(make_load(i, $urandom()));
      endcase
    end
  endtask

  // map edge cases at the reset entry count
  task automatic test_directed_maps();
    send_txn(make_map(0, 1'b1));
    send_txn(make_map(32'sh7fff_ffff, 1'b1));
    send_txn(make_map(32'sh8000_0000, 1'b1));
    send_txn(make_map(ONE / 2, 1'b1));
    send_txn(make_map(0, 1'b0));
    send_txn(make_map(-1, 1'b0));
    send_txn(make_map(32'sh8000_0000, 1'b0));
    send_txn(make_map(1, 1'b0));
    send_txn(make_map(ONE - 1, 1'b0));
    send_txn(make_map(ONE, 1'b0));
    send_txn(make_map(ONE + 1, 1'b0));
    send_txn(make_map(32'sh7fff_ffff, 1'b0));
    send_txn(make_map(ONE / 2, 1'b0));
    send_txn(make_map(ONE / 63, 1'b0));
    send_txn(make_map(ONE / 63 + 1, 1'b0));
    // reload the first entry and use it right away
    send_txn(make_load(0, 32'h00ff_00ff));
    send_txn(make_map(1, 1'b0));
    send_txn(make_map(-ONE, 1'b0));
  endtask

  // entry count extremes, including values that saturate
  task automatic test_entry_count();
    logic [COUNT_W-1:0] settings [7];
    settings = '{7'd2, 7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd3};
    foreach (settings[k]) begin
      write_entry_count(settings[k]);
      send_txn(make_map(ONE / 2, 1'b0));
      send_txn(make_map(ONE - 1, 1'b0));
      send_txn(make_map(ONE, 1'b0));
    end
  endtask

  // long receiver stall while the sender keeps pushing
  task automatic test_backpressure();
    drain();
    send_gaps = 1'b0;
    rx_stalls = 1'b0;
    rx_hold_req = 200;
    for (int i = 0; i < 40; i++) send_txn(make_map(pick_sample(), 1'b0));
  endtask

  // random phases with varied entry counts and idling
  task automatic test_random_traffic();
    logic [COUNT_W-1:0] extremes [5];
    cmap_txn_t t;
    extremes = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd1};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 5) write_entry_count(extremes[ph]);
      else write_entry_count(COUNT_W'($urandom_range(0, 127)));
      send_gaps = ph[0];
      rx_stalls = ph[1];
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          t = make_load($urandom_range(0, DEPTH - 1), $urandom());
        end else begin
          t = make_map(pick_sample(), $urandom_range(0, 9) == 0);
        end
        send_txn(t);
      end
    end
  endtask

  // result checker and receiver ready
  initial begin : result_check
    int stall_left;
    logic [COLOR_W-1:0] want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", out_ch.pixel_color);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.pixel_color !== want) begin
            if (errors < 10) begin
              $display("pixel_color mismatch: expected %h, got %h", want,
                       out_ch.pixel_color);
            end
            errors++;
          end
        end
      end
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    errors = 0;
    send_gaps = 1'b0;
    rx_stalls = 1'b0;
    rx_hold_req = 0;
    entries_setting = COUNT_RESET;
    foreach (palette[i]) palette[i] = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_LOAD;
    in_ch.entry_index <= '0;
    in_ch.entry_color <= '0;
    in_ch.sample <= '0;
    in_ch.not_finite <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_directed_maps();
    test_entry_count();
    test_backpressure();
    test_random_traffic();
    drain();

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
